// ===== design/obstacle_avoid_drive_controller_top_defines.svh =====
// Assertion macros shared by the drive controller modules.
`ifndef OBSTACLE_AVOID_DRIVE_CONTROLLER_TOP_DEFINES_SVH
`define OBSTACLE_AVOID_DRIVE_CONTROLLER_TOP_DEFINES_SVH

// Plain property, sampled on clk, off during reset.
`define OADC_ASSERT_HOLDS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, sampled on clk, off during reset.
`define OADC_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== design/oadc_pkg.sv =====
// Shared types and constants of the obstacle avoid drive controller.
package oadc_pkg;

  localparam int DIST_WIDTH_DEF = 9;
  localparam int DUTY_W         = 8;
  localparam int DET_W          = 7;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 8;

  // Shared multiplier and divider widths
  localparam int MUL_A_W = 21;
  localparam int MUL_B_W = 8;
  localparam int NUM_W   = MUL_A_W + MUL_B_W;
  localparam int DEN_W   = 21;

  // Drive constants
  localparam int DEAD_PWM   = 90;
  localparam int FULL_PWM   = 255;
  localparam int NEAR_BASE  = 10;
  localparam int NEAR_GAIN  = 30;
  localparam int REAR_LIMIT = 20;
  localparam int MIN_DIST   = 5;
  localparam int RAMP_SPAN  = FULL_PWM - DEAD_PWM;
  localparam int NEAR_TOP   = NEAR_BASE + NEAR_GAIN;
  localparam int FULL_SQ    = FULL_PWM * FULL_PWM;

  // Divide by RAMP_SPAN as (x * RAMP_RECIP) >> RAMP_SHIFT, exact for x below 26051
  localparam int RAMP_X_W   = 15;
  localparam int RAMP_RECIP = 25421;
  localparam int RAMP_SHIFT = 22;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DET_DIST = 1'b0,
    CFG_MAX_PWM  = 1'b1
  } cfg_idx_t;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MM,
    OP_MM30,
    OP_NEAR,
    OP_RAMP,
    OP_RAMP_END,
    OP_C2,
    OP_C3,
    OP_CM,
    OP_D2,
    OP_D3,
    OP_UPD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic fwd;
    logic dd_pos;
  } dp_stat_t;

endpackage

// ===== design/oadc_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`include "obstacle_avoid_drive_controller_top_defines.svh"

module oadc_div import oadc_pkg::*; #(
  parameter int NW = NUM_W,
  parameter int DW = DEN_W
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [NW-1:0] quot,
  output logic          rem_nz
);

  localparam int CNT_W = $clog2(NW + 1);

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NW-1:0]    q_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    dvs_r;

  logic [DW:0]      rem_sh;
  logic [DW+1:0]    diff;
  logic             ge;
  logic [DW-1:0]    rem_nxt;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    rem_sh  = {rem_r, q_r[NW-1]};
    diff    = {1'b0, rem_sh} - {2'b00, dvs_r};
    ge      = !diff[DW+1];
    rem_nxt = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(NW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Quotient and remainder
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[NW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign busy   = busy_r;
  assign quot   = q_r;
  assign rem_nz = |rem_r;

  `OADC_ASSERT_IMPLIES(a_rem_below_divisor, busy_r, (rem_r < dvs_r) || (dvs_r == '0), "divider remainder out of range")

endmodule

// ===== design/oadc_datapath.sv =====
// Datapath: config registers, distance latch, shared multiplier, divider, drive state.
`include "obstacle_avoid_drive_controller_top_defines.svh"

module oadc_datapath import oadc_pkg::*; #(
  parameter int DIST_WIDTH = DIST_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [DIST_WIDTH-1:0] front_left_cm,
  input  logic [DIST_WIDTH-1:0] front_right_cm,
  input  logic [DIST_WIDTH-1:0] rear_left_cm,
  input  logic [DIST_WIDTH-1:0] rear_right_cm,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat,
  output logic [DUTY_W-1:0]     motor_a_duty,
  output logic [DUTY_W-1:0]     motor_b_duty,
  output logic                  motor_a_reverse,
  output logic                  motor_b_reverse,
  output logic                  turning_now,
  output logic                  reversing_now
);

  localparam int DD_W     = DET_W + 2;
  localparam int PWM_W    = DUTY_W + 1;
  localparam int RAMP_P_W = RAMP_X_W + 15;

  // Configuration
  logic [DET_W-1:0]  det_r;
  logic [DUTY_W-1:0] mpwm_r;

  // Beat and work registers
  logic [DIST_WIDTH-1:0] fl_r, fr_r, bl_r, br_r;
  logic [NUM_W-1:0]      t_r;
  logic [DEN_W-1:0]      u_r;
  logic signed [DD_W-1:0] dd_r;
  logic                  fwd_r;

  // Drive state
  logic              turning_r, turning_nxt;
  logic              reversing_r, reversing_nxt;
  logic              dir_a_r, dir_a_nxt;
  logic              dir_b_r, dir_b_nxt;
  logic [DUTY_W-1:0] duty_a_r, duty_a_nxt;
  logic [DUTY_W-1:0] duty_b_r, duty_b_nxt;

  logic [DIST_WIDTH-1:0] f, fm9;
  logic [DUTY_W-1:0]     m_abs;
  logic [DET_W-1:0]      det_abs;
  logic [DET_W-1:0]      dd7, c;
  logic                  dd_pos;
  logic [MUL_A_W-1:0]    mul_a;
  logic [MUL_B_W-1:0]    mul_b;
  logic [NUM_W-1:0]      prod;
  logic                  near_ok;
  logic [RAMP_P_W-1:0]   ramp_prod;
  logic [DET_W-1:0]      ramp_q;
  logic                  ramp_neg;
  logic signed [DD_W-1:0] dd_nxt;
  logic [PWM_W-1:0]      pwm_up, pwm_dn;
  logic [DUTY_W-1:0]     pwm;
  logic                  rear_near;
  logic                  turn_pair;
  logic                  dir_match;

  logic                  div_start;
  logic [NUM_W-1:0]      div_dividend;
  logic [DEN_W-1:0]      div_divisor;
  logic                  div_busy;
  logic [NUM_W-1:0]      div_quot;
  logic                  div_rem_nz;

  // Derived operands
  always_comb begin
    f       = (fl_r < fr_r) ? fl_r : fr_r;
    fm9     = f - DIST_WIDTH'(NEAR_BASE - 1);
    m_abs   = (mpwm_r >= DUTY_W'(DEAD_PWM)) ? mpwm_r - DUTY_W'(DEAD_PWM)
                                            : DUTY_W'(DEAD_PWM) - mpwm_r;
    det_abs = (det_r >= DET_W'(MIN_DIST)) ? det_r - DET_W'(MIN_DIST)
                                          : DET_W'(MIN_DIST) - det_r;
    dd_pos  = !dd_r[DD_W-1] && (dd_r != '0);
    dd7     = dd_r[DET_W-1:0];
    c       = (f < DIST_WIDTH'(dd7)) ? f[DET_W-1:0] : dd7;
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_MM:   begin mul_a = MUL_A_W'(mpwm_r);          mul_b = mpwm_r;              end
      OP_MM30: begin mul_a = t_r[MUL_A_W-1:0];          mul_b = MUL_B_W'(NEAR_GAIN); end
      OP_NEAR: begin mul_a = MUL_A_W'(FULL_SQ);         mul_b = fm9[MUL_B_W-1:0];    end
      OP_RAMP: begin mul_a = MUL_A_W'(det_abs);         mul_b = m_abs;               end
      OP_C2:   begin mul_a = MUL_A_W'(c);               mul_b = MUL_B_W'(c);         end
      OP_C3:   begin mul_a = t_r[MUL_A_W-1:0];          mul_b = MUL_B_W'(c);         end
      OP_CM:   begin mul_a = t_r[MUL_A_W-1:0];          mul_b = m_abs;               end
      OP_D2:   begin mul_a = MUL_A_W'(dd7);             mul_b = MUL_B_W'(dd7);       end
      OP_D3:   begin mul_a = u_r;                       mul_b = MUL_B_W'(dd7);       end
      default: begin mul_a = '0;                        mul_b = '0;                  end
    endcase
  end

  assign prod = NUM_W'(mul_a) * NUM_W'(mul_b);

  // Near limit test: f >= 10 + floor(30*m*m/65025)
  assign near_ok = (f > DIST_WIDTH'(NEAR_TOP))
                || ((f >= DIST_WIDTH'(NEAR_BASE)) && (t_r < prod));

  // Ramp distance: |product| / 165 by reciprocal multiply, sign restored (truncates)
  always_comb begin
    ramp_prod = RAMP_P_W'(t_r[RAMP_X_W-1:0]) * RAMP_P_W'(RAMP_RECIP);
    ramp_q    = ramp_prod[RAMP_SHIFT +: DET_W];
    ramp_neg  = (mpwm_r < DUTY_W'(DEAD_PWM)) ^ (det_r < DET_W'(MIN_DIST));
    dd_nxt    = ramp_neg ? DD_W'(MIN_DIST) - DD_W'(ramp_q)
                         : DD_W'(ramp_q) + DD_W'(MIN_DIST);
  end

  // Divider hookup: cubic ratio only
  always_comb begin
    div_start    = (cmd.op == OP_D3);
    div_dividend = t_r;
    div_divisor  = prod[DEN_W-1:0];
  end

  oadc_div #(
    .NW (NUM_W),
    .DW (DEN_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem_nz   (div_rem_nz)
  );

  // Forward duty, floored in both directions
  always_comb begin
    pwm_up = PWM_W'(DEAD_PWM) + PWM_W'(div_quot[DUTY_W-1:0]);
    pwm_dn = PWM_W'(DEAD_PWM) - PWM_W'(div_quot[DUTY_W-1:0]) - PWM_W'(div_rem_nz);
    if (!dd_pos) begin
      pwm = mpwm_r;
    end else if (mpwm_r >= DUTY_W'(DEAD_PWM)) begin
      pwm = pwm_up[DUTY_W-1:0];
    end else begin
      pwm = pwm_dn[DUTY_W-1:0];
    end
  end

  assign rear_near = (bl_r < DIST_WIDTH'(REAR_LIMIT)) || (br_r < DIST_WIDTH'(REAR_LIMIT));

  // Drive state update
  always_comb begin
    turning_nxt   = turning_r;
    reversing_nxt = reversing_r;
    dir_a_nxt     = dir_a_r;
    dir_b_nxt     = dir_b_r;
    duty_a_nxt    = duty_a_r;
    duty_b_nxt    = duty_b_r;
    if (cmd.op == OP_UPD) begin
      if (fwd_r) begin
        turning_nxt   = 1'b0;
        reversing_nxt = 1'b0;
        dir_a_nxt     = 1'b0;
        dir_b_nxt     = 1'b0;
        duty_a_nxt    = pwm;
        duty_b_nxt    = pwm;
      end else begin
        if (f < DIST_WIDTH'(MIN_DIST)) begin
          reversing_nxt = 1'b1;
        end
        if (!turning_r) begin
          turning_nxt = 1'b1;
          // turn toward the farther front side
          if (fr_r < fl_r) begin
            duty_a_nxt = DUTY_W'(DEAD_PWM);
            duty_b_nxt = '0;
          end else begin
            duty_a_nxt = '0;
            duty_b_nxt = DUTY_W'(DEAD_PWM);
          end
        end
      end
      if (reversing_nxt) begin
        dir_a_nxt = 1'b1;
        dir_b_nxt = 1'b1;
        if (rear_near) begin
          if (!turning_nxt) begin
            turning_nxt = 1'b1;
            if (br_r < bl_r) begin
              duty_a_nxt = '0;
              duty_b_nxt = DUTY_W'(DEAD_PWM);
            end else begin
              duty_a_nxt = DUTY_W'(DEAD_PWM);
              duty_b_nxt = '0;
            end
          end
        end else begin
          turning_nxt = 1'b0;
          duty_a_nxt  = DUTY_W'(DEAD_PWM);
          duty_b_nxt  = DUTY_W'(DEAD_PWM);
        end
      end
    end
  end

  // Config and drive state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_r       <= DET_W'(50);
      mpwm_r      <= DUTY_W'(DEAD_PWM);
      turning_r   <= 1'b0;
      reversing_r <= 1'b0;
      dir_a_r     <= 1'b0;
      dir_b_r     <= 1'b0;
      duty_a_r    <= '0;
      duty_b_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_DET_DIST: det_r  <= cfg_data[DET_W-1:0];
          CFG_MAX_PWM:  mpwm_r <= cfg_data[DUTY_W-1:0];
          default:      det_r  <= det_r;
        endcase
      end
      turning_r   <= turning_nxt;
      reversing_r <= reversing_nxt;
      dir_a_r     <= dir_a_nxt;
      dir_b_r     <= dir_b_nxt;
      duty_a_r    <= duty_a_nxt;
      duty_b_r    <= duty_b_nxt;
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        fl_r <= front_left_cm;
        fr_r <= front_right_cm;
        bl_r <= rear_left_cm;
        br_r <= rear_right_cm;
      end
      OP_MM, OP_MM30, OP_RAMP, OP_C2, OP_C3, OP_CM: t_r <= prod;
      OP_NEAR:     fwd_r <= near_ok;
      OP_RAMP_END: dd_r  <= dd_nxt;
      OP_D2:       u_r   <= prod[DEN_W-1:0];
      default:     fwd_r <= fwd_r;
    endcase
  end

  always_comb begin
    stat.div_busy = div_busy;
    stat.fwd      = fwd_r;
    stat.dd_pos   = dd_pos;
  end

  assign motor_a_duty    = duty_a_r;
  assign motor_b_duty    = duty_b_r;
  assign motor_a_reverse = dir_a_r;
  assign motor_b_reverse = dir_b_r;
  assign turning_now     = turning_r;
  assign reversing_now   = reversing_r;

  // Checked duty pairs and directions
  assign turn_pair = ((duty_a_r == DUTY_W'(DEAD_PWM)) && (duty_b_r == '0))
                  || ((duty_a_r == '0) && (duty_b_r == DUTY_W'(DEAD_PWM)));
  assign dir_match = (dir_a_r == reversing_r) && (dir_b_r == reversing_r);

  `OADC_ASSERT_IMPLIES(a_turn_pattern, turning_r, turn_pair, "turning without a turn duty pair")
  `OADC_ASSERT_HOLDS(a_dir_tracks_rev, dir_match, "motor direction disagrees with reversing flag")

endmodule

// ===== design/oadc_ctrl.sv =====
// Controller: sequences the datapath for one beat and owns the handshakes.
`include "obstacle_avoid_drive_controller_top_defines.svh"

module oadc_ctrl import oadc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_MM,
    S_MM30,
    S_NEAR,
    S_RAMP,
    S_RAMP_END,
    S_CHK,
    S_C2,
    S_C3,
    S_CM,
    S_D2,
    S_D3,
    S_QDIV,
    S_UPD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  // Next state and datapath command
  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_MM;
        end
      end
      S_MM:       begin cmd.op = OP_MM;   state_nxt = S_MM30; end
      S_MM30:     begin cmd.op = OP_MM30; state_nxt = S_NEAR; end
      S_NEAR:     begin cmd.op = OP_NEAR; state_nxt = S_RAMP; end
      S_RAMP:     begin cmd.op = OP_RAMP; state_nxt = S_RAMP_END; end
      S_RAMP_END: begin cmd.op = OP_RAMP_END; state_nxt = S_CHK; end
      S_CHK:      state_nxt = (stat.fwd && stat.dd_pos) ? S_C2 : S_UPD;
      S_C2:       begin cmd.op = OP_C2; state_nxt = S_C3; end
      S_C3:       begin cmd.op = OP_C3; state_nxt = S_CM; end
      S_CM:       begin cmd.op = OP_CM; state_nxt = S_D2; end
      S_D2:       begin cmd.op = OP_D2; state_nxt = S_D3; end
      S_D3:       begin cmd.op = OP_D3; state_nxt = S_QDIV; end
      S_QDIV: begin
        if (!stat.div_busy) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (out_free) begin
          cmd.op    = OP_UPD;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result beat valid: set on update, cleared when taken
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.op == OP_UPD) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  `OADC_ASSERT_IMPLIES(a_out_from_upd, $rose(out_valid_r), $past(state_r == S_UPD), "result beat raised outside update")
  `OADC_ASSERT_IMPLIES(a_accept_div_idle, in_valid && in_ready, !stat.div_busy, "beat accepted while divider busy")

endmodule

// ===== design/obstacle_avoid_drive_controller_top.sv =====
// Top level of the obstacle avoid drive controller.
// Sequence: the input beat is latched, then the near and ramp steps run; when driving forward with a
// positive ramp distance, the cubic steps and one pass of the serial divider follow before the update.
// Throughput: one beat in flight; the next is taken the cycle after the result is written.
// Reset (rst_n, synchronous): drive state cleared, detection distance 50, max duty 90.
module obstacle_avoid_drive_controller_top import oadc_pkg::*; #(
  parameter int DIST_WIDTH = DIST_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input beat
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DIST_WIDTH-1:0] in_front_left_cm,
  input  logic [DIST_WIDTH-1:0] in_front_right_cm,
  input  logic [DIST_WIDTH-1:0] in_rear_left_cm,
  input  logic [DIST_WIDTH-1:0] in_rear_right_cm,
  // result beat
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DUTY_W-1:0]     out_motor_a_duty,
  output logic [DUTY_W-1:0]     out_motor_b_duty,
  output logic                  out_motor_a_reverse,
  output logic                  out_motor_b_reverse,
  output logic                  out_turning_now,
  output logic                  out_reversing_now
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  oadc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  oadc_datapath #(
    .DIST_WIDTH (DIST_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .front_left_cm   (in_front_left_cm),
    .front_right_cm  (in_front_right_cm),
    .rear_left_cm    (in_rear_left_cm),
    .rear_right_cm   (in_rear_right_cm),
    .cmd             (cmd),
    .stat            (stat),
    .motor_a_duty    (out_motor_a_duty),
    .motor_b_duty    (out_motor_b_duty),
    .motor_a_reverse (out_motor_a_reverse),
    .motor_b_reverse (out_motor_b_reverse),
    .turning_now     (out_turning_now),
    .reversing_now   (out_reversing_now)
  );

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for the obstacle avoid drive controller: sonar beats in, motor commands out.
module tb;
  import oadc_pkg::*;

  localparam int DW         = DIST_WIDTH_DEF;
  localparam int HANG_LIMIT = 2000;
  localparam int TAIL_WAIT  = 100;
  localparam int NUM_PHASES = 13;
  localparam int PHASE_BEATS = 140;

  // Motor command, also the controller's drive state
  typedef struct packed {
    logic [DUTY_W-1:0] duty_a;
    logic [DUTY_W-1:0] duty_b;
    logic              rev_a;
    logic              rev_b;
    logic              turning;
    logic              reversing;
  } drive_t;

  // One pending job: a sonar beat or a register write
  typedef struct {
    logic                  is_cfg;
    cfg_idx_t              reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic [DW-1:0]         fl, fr, rl, rr;
  } job_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index = CFG_DET_DIST;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic          in_valid = 1'b0;
  logic          in_ready;
  logic [DW-1:0] in_front_left_cm = '0;
  logic [DW-1:0] in_front_right_cm = '0;
  logic [DW-1:0] in_rear_left_cm = '0;
  logic [DW-1:0] in_rear_right_cm = '0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DUTY_W-1:0] out_motor_a_duty;
  logic [DUTY_W-1:0] out_motor_b_duty;
  logic              out_motor_a_reverse;
  logic              out_motor_b_reverse;
  logic              out_turning_now;
  logic              out_reversing_now;

  obstacle_avoid_drive_controller_top #(.DIST_WIDTH(DW)) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_front_left_cm    (in_front_left_cm),
    .in_front_right_cm   (in_front_right_cm),
    .in_rear_left_cm     (in_rear_left_cm),
    .in_rear_right_cm    (in_rear_right_cm),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_motor_a_duty    (out_motor_a_duty),
    .out_motor_b_duty    (out_motor_b_duty),
    .out_motor_a_reverse (out_motor_a_reverse),
    .out_motor_b_reverse (out_motor_b_reverse),
    .out_turning_now     (out_turning_now),
    .out_reversing_now   (out_reversing_now)
  );

  // Shadow registers and drive state
  logic [DET_W-1:0]  det_dist = 7'd50;
  logic [DUTY_W-1:0] pwm_max = 8'd90;
  drive_t            drive_state = '0;

  job_t   sonar_jobs_q[$];
  drive_t drive_expect_q[$];
  int     beats_queued = 0;
  int     beats_sent = 0;
  int     cmds_seen = 0;
  int     errors = 0;
  int     cyc = 0;
  int     idle_cycles = 0;
  logic   calm;

  // No back-pressure and no gaps inside this window
  assign calm = (cyc >= 8000) && (cyc < 20000);

  initial begin
    forever #6 clk = ~clk;
  end

  // Next drive command for one sonar beat under the current settings
  function automatic drive_t next_drive(drive_t s, logic [DW-1:0] fl, logic [DW-1:0] fr,
                                        logic [DW-1:0] rl, logic [DW-1:0] rr);
    drive_t n;
    longint m, det, f, r, lim, ramp, c, num, den, pwm;
    n   = s;
    m   = pwm_max;
    det = det_dist;
    f   = (fl < fr) ? fl : fr;
    lim = NEAR_BASE + (NEAR_GAIN * m * m) / FULL_SQ;
    // truncates toward zero
    ramp = ((m - DEAD_PWM) * (det - MIN_DIST)) / RAMP_SPAN + MIN_DIST;
    if (f >= lim) begin
      if (ramp <= 0) begin
        pwm = m;
      end else begin
        c   = (f < ramp) ? f : ramp;
        num = c * c * c * (m - DEAD_PWM);
        den = ramp * ramp * ramp;
        pwm = num / den;
        if ((num % den != 0) && (num < 0)) pwm = pwm - 1;
        pwm = pwm + DEAD_PWM;
      end
      if (pwm < 0) pwm = 0;
      if (pwm > FULL_PWM) pwm = FULL_PWM;
      n.turning   = 1'b0;
      n.reversing = 1'b0;
      n.rev_a     = 1'b0;
      n.rev_b     = 1'b0;
      n.duty_a    = pwm[DUTY_W-1:0];
      n.duty_b    = pwm[DUTY_W-1:0];
    end else begin
      if (f < MIN_DIST) n.reversing = 1'b1;
      // turn toward the farther front side, once per episode
      if (!n.turning) begin
        n.turning = 1'b1;
        n.duty_a  = (fr < fl) ? DUTY_W'(DEAD_PWM) : '0;
        n.duty_b  = (fr < fl) ? '0 : DUTY_W'(DEAD_PWM);
      end
    end
    if (n.reversing) begin
      r       = (rl < rr) ? rl : rr;
      n.rev_a = 1'b1;
      n.rev_b = 1'b1;
      if (r < REAR_LIMIT) begin
        if (!n.turning) begin
          n.turning = 1'b1;
          n.duty_a  = (rr < rl) ? '0 : DUTY_W'(DEAD_PWM);
          n.duty_b  = (rr < rl) ? DUTY_W'(DEAD_PWM) : '0;
        end
      end else begin
        n.turning = 1'b0;
        n.duty_a  = DUTY_W'(DEAD_PWM);
        n.duty_b  = DUTY_W'(DEAD_PWM);
      end
    end
    return n;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function automatic int any_dist();
    case ($urandom_range(3))
      0: return $urandom_range(0, 6);
      1: return $urandom_range(7, 45);
      2: return $urandom_range(46, 130);
      default: return $urandom_range(0, (1 << DW) - 1);
    endcase
  endfunction

  function automatic int rear_dist();
    if ($urandom_range(3) == 0) return any_dist();
    return $urandom_range(0, 40);
  endfunction

  task automatic push_reading(int fl, int fr, int rl, int rr);
    job_t j;
    j.is_cfg  = 1'b0;
    j.reg_idx = CFG_DET_DIST;
    j.reg_val = '0;
    j.fl      = fl[DW-1:0];
    j.fr      = fr[DW-1:0];
    j.rl      = rl[DW-1:0];
    j.rr      = rr[DW-1:0];
    sonar_jobs_q.push_back(j);
    beats_queued++;
  endtask

  task automatic push_setting(int det, int pwm);
    job_t j;
    j.is_cfg  = 1'b1;
    j.fl      = '0;
    j.fr      = '0;
    j.rl      = '0;
    j.rr      = '0;
    j.reg_idx = CFG_DET_DIST;
    j.reg_val = det[CFG_DATA_W-1:0];
    sonar_jobs_q.push_back(j);
    j.reg_idx = CFG_MAX_PWM;
    j.reg_val = pwm[CFG_DATA_W-1:0];
    sonar_jobs_q.push_back(j);
  endtask

  // Close in on an obstacle, get stuck and back off, then drive clear
  task automatic push_episode();
    int f, other;
    f = $urandom_range(20, 300);
    while (f > 2) begin
      other = f + int'($urandom_range(0, 60));
      if ($urandom_range(1) == 1) push_reading(f, other, rear_dist(), rear_dist());
      else push_reading(other, f, rear_dist(), rear_dist());
      f = f - int'($urandom_range(1, 30));
    end
    repeat ($urandom_range(1, 6)) begin
      push_reading($urandom_range(0, 15), $urandom_range(0, 15), rear_dist(), rear_dist());
    end
    repeat ($urandom_range(1, 3)) begin
      push_reading($urandom_range(40, (1 << DW) - 1), $urandom_range(40, (1 << DW) - 1),
                   rear_dist(), rear_dist());
    end
  endtask

  // Sender: one beat or register write offered at a time
  always @(posedge clk) begin : drive_proc
    job_t job;
    logic free, nv_in, nv_cfg;
    if (!rst_n) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) beats_sent++;
      free = (!in_valid || in_ready) && (!cfg_valid || cfg_ready);
      if (free) begin
        nv_in  = 1'b0;
        nv_cfg = 1'b0;
        if (sonar_jobs_q.size() != 0 && (calm || $urandom_range(99) >= 38)) begin
          if (!sonar_jobs_q[0].is_cfg) begin
            job = sonar_jobs_q.pop_front();
            nv_in = 1'b1;
            in_front_left_cm  <= job.fl;
            in_front_right_cm <= job.fr;
            in_rear_left_cm   <= job.rl;
            in_rear_right_cm  <= job.rr;
          end else if (beats_sent == cmds_seen) begin
            // registers change only once every command is back
            job = sonar_jobs_q.pop_front();
            nv_cfg = 1'b1;
            cfg_index <= job.reg_idx;
            cfg_data  <= job.reg_val;
          end
        end
        in_valid  <= nv_in;
        cfg_valid <= nv_cfg;
      end
    end
  end

  // Receiver and checker
  always @(posedge clk) begin : check_proc
    drive_t got, want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DET_DIST: det_dist = cfg_data[DET_W-1:0];
          CFG_MAX_PWM:  pwm_max = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        cmds_seen++;
        got.duty_a    = out_motor_a_duty;
        got.duty_b    = out_motor_b_duty;
        got.rev_a     = out_motor_a_reverse;
        got.rev_b     = out_motor_b_reverse;
        got.turning   = out_turning_now;
        got.reversing = out_reversing_now;
        if (drive_expect_q.size() == 0) begin
          $error("motor command with no sonar beat pending");
          errors++;
        end else begin
          want = drive_expect_q.pop_front();
          check_field("motor_a_duty", want.duty_a, got.duty_a);
          check_field("motor_b_duty", want.duty_b, got.duty_b);
          check_field("motor_a_reverse", want.rev_a, got.rev_a);
          check_field("motor_b_reverse", want.rev_b, got.rev_b);
          check_field("turning_now", want.turning, got.turning);
          check_field("reversing_now", want.reversing, got.reversing);
        end
      end
      if (in_valid && in_ready) begin
        drive_state = next_drive(drive_state, in_front_left_cm, in_front_right_cm,
                                 in_rear_left_cm, in_rear_right_cm);
        drive_expect_q.push_back(drive_state);
      end
      out_ready <= calm || ($urandom_range(99) >= 38);
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if (rst_n) begin
      cyc <= cyc + 1;
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= HANG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : stim_proc
    int det, pwm, goal;
    int det_pick[10];
    int pwm_pick[10];
    det_pick = '{80, 5, 5, 80, 0, 127, 40, 4, 127, 50};
    pwm_pick = '{255, 90, 255, 90, 255, 255, 0, 89, 0, 170};

    // Reset settings: near limit 13, ramp distance 5
    push_reading(511, 511, 511, 511);
    push_reading(0, 0, 0, 0);            // no echo: reverse, tie turns right
    push_reading(8, 300, 100, 100);      // still reversing, rear clear
    push_reading(300, 7, 3, 50);         // turn left, rear blocked
    push_reading(12, 12, 19, 25);
    push_reading(400, 400, 20, 20);      // clear ahead
    push_reading(12, 12, 60, 60);        // turn right on a tie
    push_reading(12, 11, 60, 60);        // same episode, no new turn
    push_reading(13, 200, 5, 5);         // exactly at the near limit
    push_reading(4, 9, 19, 19);
    // Full range: near limit 40, ramp distance 80
    push_setting(80, 255);
    push_reading(39, 300, 0, 0);
    push_reading(40, 40, 200, 200);
    push_reading(80, 81, 0, 0);
    push_reading(511, 256, 256, 511);
    push_reading(2, 100, 19, 20);
    push_reading(30, 30, 20, 20);        // rear exactly at its limit
    // Ramp distance zero: full duty at once
    push_setting(0, 255);
    push_reading(45, 45, 0, 0);
    // Max duty below the dead band, ramp negative
    push_setting(127, 0);
    push_reading(10, 10, 30, 30);
    push_reading(9, 50, 30, 30);
    push_setting(0, 0);
    push_reading(10, 10, 30, 30);
    push_setting(4, 89);
    push_reading(13, 13, 30, 30);

    // Random phases: mostly obstacle episodes, some noise
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 10) begin
        det = det_pick[p];
        pwm = pwm_pick[p];
      end else begin
        det = $urandom_range(5, 80);
        pwm = $urandom_range(90, 255);
      end
      push_setting(det, pwm);
      goal = beats_queued + PHASE_BEATS;
      while (beats_queued < goal) begin
        if ($urandom_range(9) < 7) push_episode();
        else push_reading(any_dist(), any_dist(), rear_dist(), any_dist());
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (sonar_jobs_q.size() != 0 || in_valid || cfg_valid || beats_sent != cmds_seen)
      @(negedge clk);
    repeat (TAIL_WAIT) @(negedge clk);
    if (drive_expect_q.size() != 0) begin
      $error("%0d motor commands never arrived", drive_expect_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
